### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and masked during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// payload types and fixed constants of the sha-1 digest core
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  localparam int unsigned SHA1_WORDS = 5;

  // entry 0 is H0
  localparam logic [SHA1_WORDS-1:0][31:0] SHA1_H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // entry 0 serves rounds 0 to 19
  localparam logic [3:0][31:0] SHA1_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [2:0] SHA1_LAST_INDEX = 3'd4;

endpackage

### rtl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// byte-serial sha-1 engine: one round per cycle on a single round adder
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  msg     | in        | msg_valid, msg_stall | msg_item  (sha1_in_t)
//  dig     | out       | dig_valid, dig_stall | dig_item  (sha1_out_t)
//
//  a byte item is taken in ST_IDLE; the 64th byte of a block starts 80 rounds
//  on the shared round adder, then ST_ADD adds the working words to the chain.
//  an end item pads at one byte a cycle (up to 72 bytes), with one or two
//  compressions (ST_ROUND, ST_ADD), then shows five digest words in turn.
//  reset is synchronous and needs no clearing pass; msg_stall is high
//  whenever the core is not idle, and dig_stall simply holds the current word.
module sha1_message_digest_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_stall,
  input  sha1_pkg::sha1_in_t  msg_item,
  output logic                dig_valid,
  input  logic                dig_stall,
  output sha1_pkg::sha1_out_t dig_item
);
  import sha1_pkg::*;

  localparam logic [5:0] FILL_LAST = 6'h3F;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  state_t                      state;
  logic [SHA1_WORDS-1:0][31:0] chain;
  logic [511:0]                wbuf;
  logic [5:0]                  fill;
  logic [63:0]                 bit_length;
  logic [31:0]                 va, vb, vc, vd, ve;
  logic [6:0]                  round;
  logic                        marker_sent;
  logic                        len_phase;
  logic                        pad_done;
  logic                        pending_end;
  logic [2:0]                  word_idx;

  logic        msg_xfer, dig_xfer;
  logic        sel_len;
  logic [7:0]  pad_byte;
  logic [31:0] f_val, k_val, w_new, t_sum;

  assign msg_stall = (state != ST_IDLE);
  assign msg_xfer  = msg_valid && !msg_stall;
  assign dig_valid = (state == ST_EMIT);
  assign dig_xfer  = dig_valid && !dig_stall;

  assign dig_item.digest_word = chain[word_idx];
  assign dig_item.word_index  = word_idx;
  assign dig_item.last_word   = (word_idx == SHA1_LAST_INDEX);

  // padding source: marker, then zeros, then the length from byte 56 on
  assign sel_len  = marker_sent && (len_phase || fill == LEN_POS);
  assign pad_byte = !marker_sent ? 8'h80 : (sel_len ? bit_length[63:56] : 8'h00);

  // round function and schedule; wbuf holds w[t..t+15], w[t] at the top
  always_comb begin
    if (round < 7'd20) begin
      f_val = (vb & vc) | (~vb & vd);
      k_val = SHA1_K[0];
    end else if (round < 7'd40) begin
      f_val = vb ^ vc ^ vd;
      k_val = SHA1_K[1];
    end else if (round < 7'd60) begin
      f_val = (vb & vc) | (vb & vd) | (vc & vd);
      k_val = SHA1_K[2];
    end else begin
      f_val = vb ^ vc ^ vd;
      k_val = SHA1_K[3];
    end
    w_new = wbuf[511-32*13 -: 32] ^ wbuf[511-32*8 -: 32]
          ^ wbuf[511-32*2 -: 32] ^ wbuf[511 -: 32];
    w_new = {w_new[30:0], w_new[31]};
    t_sum = {va[26:0], va[31:27]} + f_val + ve + wbuf[511 -: 32] + k_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chain       <= SHA1_H_INIT;
      fill        <= '0;
      bit_length  <= '0;
      round       <= '0;
      marker_sent <= 1'b0;
      len_phase   <= 1'b0;
      pad_done    <= 1'b0;
      pending_end <= 1'b0;
      word_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_xfer) begin
            if (msg_item.has_byte) begin
              wbuf       <= {wbuf[503:0], msg_item.data_byte};
              fill       <= fill + 6'd1;
              bit_length <= bit_length + 64'd8;
            end
            if (msg_item.end_of_message) begin
              pending_end <= 1'b1;
              state       <= ST_PAD;
            end
            if (msg_item.has_byte && fill == FILL_LAST) begin
              {va, vb, vc, vd, ve} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
              round <= '0;
              state <= ST_ROUND;
            end
          end
        end
        ST_PAD: begin
          wbuf        <= {wbuf[503:0], pad_byte};
          fill        <= fill + 6'd1;
          marker_sent <= 1'b1;
          if (sel_len) begin
            len_phase  <= 1'b1;
            bit_length <= {bit_length[55:0], 8'h00};
          end
          if (fill == FILL_LAST) begin
            if (sel_len) begin
              pad_done <= 1'b1;
            end
            {va, vb, vc, vd, ve} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
            round <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          wbuf  <= {wbuf[479:0], w_new};
          va    <= t_sum;
          vb    <= va;
          vc    <= {vb[1:0], vb[31:2]};
          vd    <= vc;
          ve    <= vd;
          round <= round + 7'd1;
          if (round == ROUND_LAST) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          if (pad_done) begin
            word_idx <= '0;
            state    <= ST_EMIT;
          end else if (pending_end) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (dig_xfer) begin
            if (word_idx == SHA1_LAST_INDEX) begin
              // back to the initial state for the next message
              chain       <= SHA1_H_INIT;
              fill        <= '0;
              bit_length  <= '0;
              marker_sent <= 1'b0;
              len_phase   <= 1'b0;
              pad_done    <= 1'b0;
              pending_end <= 1'b0;
              word_idx    <= '0;
              state       <= ST_IDLE;
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks on the digest core, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_checker (
  input logic                clk,
  input logic                rst,
  input logic                msg_valid,
  input logic                msg_stall,
  input logic                dig_valid,
  input logic                dig_stall,
  input sha1_pkg::sha1_out_t dig_item
);
  import sha1_pkg::*;

  // a held word stays put
  `ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(dig_item))

  // no new message transfer while digest words are pending
  `ASSERT_SAME(a_busy_emit, dig_valid, msg_stall)

  `ASSERT_SAME(a_last_pos, dig_valid, dig_item.last_word == (dig_item.word_index == SHA1_LAST_INDEX))

  // words follow one another in order
  `ASSERT_NEXT(a_word_order, dig_valid && !dig_stall && !dig_item.last_word, dig_valid && dig_item.word_index == $past(dig_item.word_index) + 3'd1)

  // an accepted message item cannot be followed at once by a digest word
  `ASSERT_NEXT(a_no_early_dig, msg_valid && !msg_stall, !dig_valid)

endmodule

bind sha1_message_digest_core sha1_checker u_sha1_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_stall (msg_stall),
  .dig_valid (dig_valid),
  .dig_stall (dig_stall),
  .dig_item  (dig_item)
);

### dv/tb_sha1_message_digest_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_core
// feeds byte messages of random length and content, with empty messages,
// ignored items and block-boundary lengths, and checks every digest word
// against a sha-1 computed alongside in the bench, under random stalls
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_core;
  import sha1_pkg::*;

  class sha1_digest_tracker;
    logic [31:0] chain_words [SHA1_WORDS];
    logic [7:0]  block_buf [64];
    logic [5:0]  fill;
    logic [63:0] length_bits;
    sha1_out_t   pending_words [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < SHA1_WORDS; i++) chain_words[i] = SHA1_H_INIT[i];
      fill = '0;
      length_bits = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, sum;
      int s;
      for (int t = 0; t < 16; t++)
        w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int t = 0; t < 80; t++) begin
        s = t % 16;
        // message schedule kept in a 16-word ring
        if (t >= 16) begin
          x = w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s];
          w[s] = {x[30:0], x[31]};
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = SHA1_K[0];
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = SHA1_K[1];
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = SHA1_K[2];
        end else begin
          f = b ^ c ^ d;
          k = SHA1_K[3];
        end
        sum = {a[26:0], a[31:27]} + f + e + w[s] + k;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = sum;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
    endfunction

    function void absorb(logic [7:0] v);
      block_buf[fill] = v;
      fill++;
      if (fill == 0) compress();
    endfunction

    function void take_msg_item(sha1_in_t it);
      logic [63:0] len;
      sha1_out_t   word;
      if (it.has_byte) begin
        absorb(it.data_byte);
        length_bits += 64'd8;
      end
      if (!it.end_of_message) return;
      len = length_bits;
      absorb(8'h80);
      while (fill != 6'd56) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(len[63 - 8*i -: 8]);
      for (int i = 0; i < SHA1_WORDS; i++) begin
        word.digest_word = chain_words[i];
        word.word_index  = 3'(i);
        word.last_word   = (3'(i) == SHA1_LAST_INDEX);
        pending_words.push_back(word);
      end
      restart();
    endfunction

    function void check_digest_word(sha1_out_t got);
      sha1_out_t want;
      if (pending_words.size() == 0) begin
        $error("digest word with none expected: %h", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word expected %0b actual %0b", want.last_word, got.last_word);
        errors++;
      end
    endfunction

    function int words_pending();
      return pending_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      msg_valid;
  logic      msg_stall;
  sha1_in_t  msg_item;
  logic      dig_valid;
  logic      dig_stall;
  sha1_out_t dig_item;

  sha1_digest_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_requests;
  int items_sent;

  sha1_message_digest_core dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_item  (msg_item),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig_item  (dig_item)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: checks each word transfer and decides the stall for the next edge
  initial begin
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && dig_valid && !dig_stall) tracker.check_digest_word(dig_item);
      if (holds_seen != hold_off_requests) begin
        holds_seen++;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        dig_stall <= 1'b1;
        stall_left--;
      end else begin
        dig_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic offer_item(input logic [7:0] b, input logic hb, input logic eom);
    sha1_in_t it;
    it.data_byte      = b;
    it.has_byte       = hb;
    it.end_of_message = eom;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg_item  <= it;
    do @(posedge clk); while (msg_stall);
    tracker.take_msg_item(it);
    if (hb || eom) items_sent++;
  endtask

  // byte-carrying end or a separate end item, with the odd ignored item mixed in
  task automatic send_message(input int len, input bit close_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      offer_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (len == 0 || !close_on_byte) offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic pause_until_drained();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (tracker.words_pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 6);
    if (r < 72) return $urandom_range(7, 40);
    if (r < 95) return $urandom_range(53, 66);
    return $urandom_range(118, 130);
  endfunction

  task automatic run_random(input int upto);
    while (items_sent < upto) send_message(pick_length(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int guard;
    tracker = new();
    clk = 1'b0;
    rst = 1'b1;
    msg_valid = 1'b0;
    msg_item = '0;
    dig_stall = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 23;
    hold_off_requests = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    recv_idle_pct <= 46;

    // directed: ignored item, empty message, single extreme bytes, "abc", separate end
    offer_item(8'hFF, 1'b0, 1'b0);
    offer_item(8'h00, 1'b0, 1'b1);
    offer_item(8'h00, 1'b1, 1'b1);
    offer_item(8'hFF, 1'b1, 1'b1);
    offer_item(8'h61, 1'b1, 1'b0);
    offer_item(8'h62, 1'b1, 1'b0);
    offer_item(8'hA5, 1'b0, 1'b0);
    offer_item(8'h63, 1'b1, 1'b1);
    offer_item(8'hAA, 1'b1, 1'b0);
    offer_item(8'h55, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b0, 1'b1);
    pause_until_drained();

    // long receiver hold-off while the sender keeps offering
    hold_off_requests <= hold_off_requests + 1;
    send_message(3, 1'b1);
    send_message(2, 1'b0);
    send_message(64, 1'b1);
    pause_until_drained();

    run_random(130);
    pause_until_drained();

    send_idle_pct = 46;
    recv_idle_pct <= 23;
    run_random(180);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(225);

    msg_valid <= 1'b0;
    guard = 0;
    while (tracker.words_pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
    if (tracker.words_pending() != 0) begin
      $error("%0d digest words never arrived", tracker.words_pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
